// File: sv/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types, widths and constants of the supersample box resolve block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  // channel and register widths
  localparam int COLOR_W    = 16;
  localparam int DEPTH_W    = 24;
  localparam int CFG_DIM_W  = 13;
  localparam int FACTOR_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // block geometry
  localparam int MAX_FACTOR_C = 8;
  localparam int MAX_WIDTH_C  = 4096;
  localparam int CIB_W        = $clog2(MAX_FACTOR_C);
  localparam int POS_W        = CFG_DIM_W + 1;
  localparam int SUM_W        = COLOR_W + 2 * CIB_W;

  // reciprocal multiply for the division by factor squared
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(480);
  localparam logic [FACTOR_W-1:0]  FACTOR_RESET = FACTOR_W'(2);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SCALE_FACTOR  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic multiply;
    logic load;
  } sbr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit;
    logic out_free;
  } sbr_status_t;

  // ceil(2^28 / f^2), exact floor division for sums below 2^22
  function automatic logic [RECIP_W-1:0] recip_area(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    unique case (f)
      4'd1:    r = RECIP_W'(268435456);
      4'd2:    r = RECIP_W'(67108864);
      4'd3:    r = RECIP_W'(29826162);
      4'd4:    r = RECIP_W'(16777216);
      4'd5:    r = RECIP_W'(10737419);
      4'd6:    r = RECIP_W'(7456541);
      4'd7:    r = RECIP_W'(5478275);
      4'd8:    r = RECIP_W'(4194304);
      default: r = RECIP_W'(268435456);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/sbr_pix_if.sv
// ----------------------------------------------------------------------------
// sbr_pix_if
// Source pixel channel: colour in linear light plus depth.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbr_pix_if;
  logic                         valid;
  logic                         ready;
  logic [sbr_pkg::COLOR_W-1:0]  red;
  logic [sbr_pkg::COLOR_W-1:0]  green;
  logic [sbr_pkg::COLOR_W-1:0]  blue;
  logic [sbr_pkg::DEPTH_W-1:0]  sample_depth;

  modport source (output valid, red, green, blue, sample_depth, input ready);
  modport sink   (input valid, red, green, blue, sample_depth, output ready);
endinterface

`default_nettype wire

// File: sv/sbr_res_if.sv
// ----------------------------------------------------------------------------
// sbr_res_if
// Resolved pixel channel with row and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbr_res_if;
  logic                         valid;
  logic                         ready;
  logic [sbr_pkg::COLOR_W-1:0]  out_red;
  logic [sbr_pkg::COLOR_W-1:0]  out_green;
  logic [sbr_pkg::COLOR_W-1:0]  out_blue;
  logic [sbr_pkg::DEPTH_W-1:0]  resolved_depth;
  logic                         end_of_row;
  logic                         end_of_frame;

  modport source (output valid, out_red, out_green, out_blue, resolved_depth,
                  end_of_row, end_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, resolved_depth,
                  end_of_row, end_of_frame, output ready);
endinterface

`default_nettype wire

// File: sv/sbr_cfg_if.sv
// ----------------------------------------------------------------------------
// sbr_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbr_pkg::CFG_IDX_W-1:0]   index;
  logic [sbr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/supersample_box_resolve.sv
// ----------------------------------------------------------------------------
// supersample_box_resolve
// Box-filter downsample of a raster pixel stream with depth minimum.
// ----------------------------------------------------------------------------
// Each source pixel passes through these steps: capture with the column memory
// read, read-modify-write of the column accumulator, the reciprocal multiply
// that divides by factor squared, and hand-off to the output register. The
// output register decouples the result side, so a waiting result holds back a
// new pixel only while the next result is ready to leave. Every factor-by-factor
// block yields one pixel with the floored colour average and the minimum depth;
// remainder pixels at the right and bottom are taken and dropped, and a register
// write to a used index restarts the frame. There is no clearing pass after
// reset.
`default_nettype none

module supersample_box_resolve #(
  parameter int MAX_WIDTH = sbr_pkg::MAX_WIDTH_C
) (
  input wire logic  clk,
  input wire logic  rst,
  sbr_pix_if.sink   pix,
  sbr_res_if.source res,
  sbr_cfg_if.sink   cfg
);
  import sbr_pkg::*;

  sbr_cmd_t    cmd;
  sbr_status_t status;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer
  sbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_ready (pix.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  sbr_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .in_red    (pix.red),
    .in_green  (pix.green),
    .in_blue   (pix.blue),
    .in_depth  (pix.sample_depth),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_red   (res.out_red),
    .out_green (res.out_green),
    .out_blue  (res.out_blue),
    .out_depth (res.resolved_depth),
    .out_eor   (res.end_of_row),
    .out_eof   (res.end_of_frame)
  );

endmodule

`default_nettype wire

// File: sv/sbr_ctrl.sv
// ----------------------------------------------------------------------------
// sbr_ctrl
// Sequencer: capture, column read-modify-write, divide, hand-off to output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sbr_pkg::sbr_status_t status,
  output sbr_pkg::sbr_cmd_t         cmd
);
  import sbr_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.emit) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/sbr_dp.sv
// ----------------------------------------------------------------------------
// sbr_dp
// Datapath: registers, position counters, column accumulator memory,
// reciprocal divide and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_dp #(
  parameter int MAX_WIDTH = sbr_pkg::MAX_WIDTH_C
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sbr_pkg::sbr_cmd_t               cmd,
  output sbr_pkg::sbr_status_t                 status,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // source pixel
  input  wire logic [sbr_pkg::COLOR_W-1:0]     in_red,
  input  wire logic [sbr_pkg::COLOR_W-1:0]     in_green,
  input  wire logic [sbr_pkg::COLOR_W-1:0]     in_blue,
  input  wire logic [sbr_pkg::DEPTH_W-1:0]     in_depth,
  // result
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sbr_pkg::COLOR_W-1:0]          out_red,
  output logic [sbr_pkg::COLOR_W-1:0]          out_green,
  output logic [sbr_pkg::COLOR_W-1:0]          out_blue,
  output logic [sbr_pkg::DEPTH_W-1:0]          out_depth,
  output logic                                 out_eor,
  output logic                                 out_eof
);
  import sbr_pkg::*;

  localparam int SLOTS  = MAX_WIDTH / 2;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int ENTRY_W = 3 * SUM_W + DEPTH_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  // registers
  logic [CFG_DIM_W-1:0] width_reg, height_reg;
  logic [FACTOR_W-1:0]  factor_reg;

  // effective geometry
  logic [FACTOR_W-1:0] f_eff;
  logic [POS_W-1:0]    w_eff, h_eff, f_pos, f2_pos;

  // position counters
  logic [POS_W-1:0]  scol, srow, col_start, row_start;
  logic [CIB_W-1:0]  cib, rib;
  logic [ADDR_W-1:0] ocol;

  // captured pixel and memory read
  logic [COLOR_W-1:0] px_r, px_g, px_b;
  logic [DEPTH_W-1:0] px_d;
  logic [ENTRY_W-1:0] line_mem [SLOTS];
  logic [ENTRY_W-1:0] rd_data;

  // accumulate stage
  logic [SUM_W-1:0]   acc_r, acc_g, acc_b;
  logic [DEPTH_W-1:0] acc_d;
  logic [RECIP_W-1:0] recip;
  logic               emit, eor, eof;

  // divide stage
  logic [COLOR_W-1:0] q_r, q_g, q_b;
  logic [DEPTH_W-1:0] q_d;
  logic               q_eor, q_eof;

  // combinational update values
  logic               first, in_range, f_one, last_cib, last_rib;
  logic               row_end, frame_end;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [DEPTH_W-1:0] min_d;
  logic [PROD_W-1:0]  prod_r, prod_g, prod_b;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      factor_reg <= FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
        REG_SOURCE_HEIGHT: height_reg <= cfg_data;
        REG_SCALE_FACTOR:  factor_reg <= cfg_data[FACTOR_W-1:0];
        REG_UNUSED:        ;
        default:           ;
      endcase
    end
  end

  // clamp geometry into range
  always_comb begin
    f_eff = factor_reg;
    if (factor_reg == '0) f_eff = FACTOR_W'(1);
    else if (32'(factor_reg) > MAX_FACTOR_C) f_eff = FACTOR_W'(MAX_FACTOR_C);
    w_eff = POS_W'(width_reg);
    if (width_reg == '0) w_eff = POS_W'(1);
    else if (32'(width_reg) > MAX_WIDTH) w_eff = POS_W'(MAX_WIDTH);
    h_eff = (height_reg == '0) ? POS_W'(1) : POS_W'(height_reg);
    f_pos  = POS_W'(f_eff);
    f2_pos = POS_W'({f_eff, 1'b0});
  end

  // block position decode
  always_comb begin
    f_one     = (f_eff == FACTOR_W'(1));
    last_cib  = (FACTOR_W'(cib) + FACTOR_W'(1) == f_eff);
    last_rib  = (FACTOR_W'(rib) + FACTOR_W'(1) == f_eff);
    first     = (cib == '0) && (rib == '0);
    in_range  = (col_start + f_pos <= w_eff) && (row_start + f_pos <= h_eff);
    row_end   = (scol + POS_W'(1) >= w_eff);
    frame_end = (srow + POS_W'(1) >= h_eff);
  end

  // accumulate against the column entry
  always_comb begin
    if (first) begin
      sum_r = SUM_W'(px_r);
      sum_g = SUM_W'(px_g);
      sum_b = SUM_W'(px_b);
      min_d = px_d;
    end else begin
      sum_r = rd_data[3*SUM_W+DEPTH_W-1 -: SUM_W] + SUM_W'(px_r);
      sum_g = rd_data[2*SUM_W+DEPTH_W-1 -: SUM_W] + SUM_W'(px_g);
      sum_b = rd_data[SUM_W+DEPTH_W-1 -: SUM_W] + SUM_W'(px_b);
      min_d = (px_d < rd_data[DEPTH_W-1:0]) ? px_d : rd_data[DEPTH_W-1:0];
    end
  end

  // column memory, read at capture and written at update
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= line_mem[ocol];
    end
    if (cmd.update && in_range && !f_one) begin
      line_mem[ocol] <= {sum_r, sum_g, sum_b, min_d};
    end
  end

  // pixel capture and accumulate registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_red;
      px_g <= in_green;
      px_b <= in_blue;
      px_d <= in_depth;
    end
    if (cmd.update) begin
      acc_r <= sum_r;
      acc_g <= sum_g;
      acc_b <= sum_b;
      acc_d <= min_d;
      recip <= recip_area(f_eff);
      eor   <= (col_start + f2_pos > w_eff);
      eof   <= (col_start + f2_pos > w_eff) && (row_start + f2_pos > h_eff);
    end
  end

  // emit flag is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      emit <= 1'b0;
    end else if (cmd.update) begin
      emit <= in_range && (f_one || (last_cib && last_rib));
    end
  end

  // position counters, restarted by a register write to any index but the unused one
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && reg_idx_t'(cfg_index) != REG_UNUSED)) begin
      scol      <= '0;
      srow      <= '0;
      col_start <= '0;
      row_start <= '0;
      cib       <= '0;
      rib       <= '0;
      ocol      <= '0;
    end else if (cmd.update) begin
      if (row_end) begin
        scol      <= '0;
        cib       <= '0;
        ocol      <= '0;
        col_start <= '0;
        if (frame_end) begin
          srow      <= '0;
          rib       <= '0;
          row_start <= '0;
        end else begin
          srow <= srow + POS_W'(1);
          if (last_rib) begin
            rib       <= '0;
            row_start <= row_start + f_pos;
          end else begin
            rib <= rib + CIB_W'(1);
          end
        end
      end else begin
        scol <= scol + POS_W'(1);
        if (last_cib) begin
          cib       <= '0;
          ocol      <= ocol + ADDR_W'(1);
          col_start <= col_start + f_pos;
        end else begin
          cib <= cib + CIB_W'(1);
        end
      end
    end
  end

  // divide by area through the reciprocal
  assign prod_r = PROD_W'(acc_r) * PROD_W'(recip);
  assign prod_g = PROD_W'(acc_g) * PROD_W'(recip);
  assign prod_b = PROD_W'(acc_b) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      q_r   <= prod_r[RECIP_SHIFT +: COLOR_W];
      q_g   <= prod_g[RECIP_SHIFT +: COLOR_W];
      q_b   <= prod_b[RECIP_SHIFT +: COLOR_W];
      q_d   <= acc_d;
      q_eor <= eor;
      q_eof <= eof;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_red   <= q_r;
      out_green <= q_g;
      out_blue  <= q_b;
      out_depth <= q_d;
      out_eor   <= q_eor;
      out_eof   <= q_eof;
    end
  end

  assign status.emit     = emit;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the supersample box resolve block.
// Pixels come from a queue that an initial block fills; that block also makes
// the register writes. A clocked driver sends pixels with random gaps, a clocked
// monitor checks results, with random stalls, against the box-filter prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbr_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DEPTH_W-1:0] depth;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DEPTH_W-1:0] depth;
    logic               eor;
    logic               eof;
  } resolved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbr_pix_if pix ();
  sbr_res_if res ();
  sbr_cfg_if cfg ();

  supersample_box_resolve dut (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg));

  always #4 clk = ~clk;

  // predictor state
  int unsigned width_reg, height_reg, factor_reg;
  int unsigned red_acc [2048];
  int unsigned green_acc [2048];
  int unsigned blue_acc [2048];
  int unsigned depth_min [2048];
  int unsigned src_col, src_row, col_in_blk, row_in_blk, out_col;

  resolved_t expected_q[$];
  pixel_t    pixel_q[$];
  int        errors = 0;
  int        pixels_sent = 0;
  int        results_seen = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic void restart_frame();
    src_col = 0; src_row = 0; col_in_blk = 0; row_in_blk = 0; out_col = 0;
  endfunction

  function automatic void write_register(input reg_idx_t idx, input int unsigned val);
    case (idx)
      REG_SOURCE_WIDTH:  width_reg = val & 13'h1fff;
      REG_SOURCE_HEIGHT: height_reg = val & 13'h1fff;
      REG_SCALE_FACTOR:  factor_reg = val & 4'hf;
      default: return;
    endcase
    restart_frame();
  endfunction

  // box-filter prediction of one accepted pixel
  function automatic void resolve_pixel(input pixel_t p);
    int unsigned f, w, h, ow, uw, uh, i;
    bit last_col, last_row;
    resolved_t r;
    f = factor_reg; w = width_reg; h = height_reg;
    if (f < 1) f = 1;
    if (f > 8) f = 8;
    if (w < 1) w = 1;
    if (w > 4096) w = 4096;
    if (h < 1) h = 1;
    ow = w / f;
    uw = ow * f;
    uh = (h / f) * f;
    if (src_col < uw && src_row < uh) begin
      last_col = (out_col + 1 == ow);
      last_row = (src_row + 1 == uh);
      r.eor = last_col;
      r.eof = last_col && last_row;
      if (f == 1) begin
        r.red = p.red; r.green = p.green; r.blue = p.blue; r.depth = p.depth;
        expected_q.push_back(r);
      end else if (out_col < 2048) begin
        i = out_col;
        if (col_in_blk == 0 && row_in_blk == 0) begin
          red_acc[i] = p.red; green_acc[i] = p.green; blue_acc[i] = p.blue;
          depth_min[i] = p.depth;
        end else begin
          red_acc[i] += p.red; green_acc[i] += p.green; blue_acc[i] += p.blue;
          if (p.depth < depth_min[i]) depth_min[i] = p.depth;
        end
        if (col_in_blk == f - 1 && row_in_blk == f - 1) begin
          r.red = COLOR_W'(red_acc[i] / (f * f));
          r.green = COLOR_W'(green_acc[i] / (f * f));
          r.blue = COLOR_W'(blue_acc[i] / (f * f));
          r.depth = DEPTH_W'(depth_min[i]);
          expected_q.push_back(r);
        end
      end
    end
    col_in_blk++;
    if (col_in_blk >= f) begin
      col_in_blk = 0;
      out_col++;
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0; col_in_blk = 0; out_col = 0;
      row_in_blk++;
      if (row_in_blk >= f) row_in_blk = 0;
      src_row++;
      if (src_row >= h) begin
        src_row = 0; row_in_blk = 0;
      end
    end
  endfunction

  // pixel driver with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      gap_left <= 0;
    end else if (pix.valid && !pix.ready) begin
      // hold the beat
    end else begin
      if (pix.valid) begin
        resolve_pixel({pix.red, pix.green, pix.blue, pix.sample_depth});
        pixels_sent++;
      end
      if (gap_left > 0) begin
        pix.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() > 0) begin
        pixel_t p;
        p = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.red <= p.red; pix.green <= p.green; pix.blue <= p.blue;
        pix.sample_depth <= p.depth;
        gap_left <= (($urandom % 4) == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res.valid && res.ready) begin
        resolved_t e;
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (res.out_red !== e.red) report("out_red", res.out_red, e.red);
          if (res.out_green !== e.green) report("out_green", res.out_green, e.green);
          if (res.out_blue !== e.blue) report("out_blue", res.out_blue, e.blue);
          if (res.resolved_depth !== e.depth)
            report("resolved_depth", res.resolved_depth, e.depth);
          if (res.end_of_row !== e.eor) report("end_of_row", res.end_of_row, e.eor);
          if (res.end_of_frame !== e.eof) report("end_of_frame", res.end_of_frame, e.eof);
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        res.ready <= 1'b1;
        if (res.valid && res.ready)
          stall_left <= (($urandom % 4) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red = COLOR_W'($urandom);
    p.green = COLOR_W'($urandom);
    p.blue = COLOR_W'($urandom);
    p.depth = DEPTH_W'($urandom);
    case ($urandom_range(0, 5))
      0: p = '1;
      1: p = '0;
      2: p.depth = DEPTH_FAR;
      default: ;
    endcase
    return p;
  endfunction

  // register write, only while the block is idle
  task automatic config_write(input reg_idx_t idx, input int unsigned val);
    cfg.index <= idx;
    cfg.data <= val[CFG_DATA_W-1:0];
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    write_register(idx, val);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || pix.valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(input int unsigned w, input int unsigned h, input int unsigned f);
    wait_idle();
    config_write(REG_SOURCE_WIDTH, w);
    config_write(REG_SOURCE_HEIGHT, h);
    config_write(REG_SCALE_FACTOR, f);
  endtask

  task automatic send_frames(input int n);
    for (int k = 0; k < n; k++) pixel_q.push_back(random_pixel());
  endtask

  // stimulus
  initial begin
    pixel_t p;
    width_reg = 640; height_reg = 480; factor_reg = 2;
    restart_frame();
    pix.valid = 1'b0; pix.red = '0; pix.green = '0; pix.blue = '0; pix.sample_depth = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = REG_SOURCE_WIDTH; cfg.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes in a 4x2 frame with factor 2, then unused index
    setup(4, 2, 2);
    p = '1; pixel_q.push_back(p); pixel_q.push_back(p);
    p = '0; pixel_q.push_back(p); pixel_q.push_back(p);
    p = '1; pixel_q.push_back(p); pixel_q.push_back(p);
    p = '0; pixel_q.push_back(p); pixel_q.push_back(p);
    wait_idle();
    config_write(REG_UNUSED, 13'h1fff);
    // pass-through, factor zero, oversized factor, factor beyond a dimension, zero size
    setup(3, 2, 1); send_frames(6);
    setup(2, 1, 0); send_frames(3);
    setup(16, 9, 15); send_frames(8);
    setup(3, 5, 4); send_frames(4);
    setup(0, 0, 1); send_frames(2);

    // random phases, mostly small frames with remainders
    for (int ph = 0; ph < 30; ph++) begin
      int unsigned w, h, f;
      f = $urandom_range(1, 8);
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 20);
      if (ph == 5) begin w = 8191; h = 8; f = 8; end
      if (ph == 6) begin w = 4096; h = 2; f = 2; end
      if (ph == 7) begin w = 5000; h = 1; f = 1; end
      setup(w, h, f);
      send_frames((ph >= 5 && ph <= 7) ? 120 : $urandom_range(30, 60));
    end

    // wide frame, leading part of the first row only
    setup(4096, 2, 2);
    send_frames(48);

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // overall limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/sbr_pkg.sv
sv/sbr_pix_if.sv
sv/sbr_res_if.sv
sv/sbr_cfg_if.sv
sv/sbr_ctrl.sv
sv/sbr_dp.sv
sv/supersample_box_resolve.sv
tb/tb.sv
